FILE: rtl/core/auc_pkg.sv
// Shared types and encodings for the ARM instruction micro-op cracker.
package auc_pkg;

	localparam int UOPS_MAX = 3;
	localparam int CNT_W    = 2;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [1:0] LIMIT_RESET = 2'd3;

	// instruction opcodes
	localparam logic [4:0] OP_NOP  = 5'd3;
	localparam logic [4:0] OP_B    = 5'd4;
	localparam logic [4:0] OP_BL   = 5'd5;
	localparam logic [4:0] OP_BX   = 5'd6;
	localparam logic [4:0] OP_BLX  = 5'd7;
	localparam logic [4:0] OP_LDR  = 5'd8;
	localparam logic [4:0] OP_LDRB = 5'd9;
	localparam logic [4:0] OP_STR  = 5'd10;
	localparam logic [4:0] OP_STRB = 5'd11;
	localparam logic [4:0] OP_AND  = 5'd12;
	localparam logic [4:0] OP_EOR  = 5'd13;
	localparam logic [4:0] OP_SUB  = 5'd14;
	localparam logic [4:0] OP_RSB  = 5'd15;
	localparam logic [4:0] OP_ADD  = 5'd16;
	localparam logic [4:0] OP_ADC  = 5'd17;
	localparam logic [4:0] OP_SBC  = 5'd18;
	localparam logic [4:0] OP_RSC  = 5'd19;
	localparam logic [4:0] OP_TST  = 5'd20;
	localparam logic [4:0] OP_TEQ  = 5'd21;
	localparam logic [4:0] OP_CMP  = 5'd22;
	localparam logic [4:0] OP_CMN  = 5'd23;
	localparam logic [4:0] OP_ORR  = 5'd24;
	localparam logic [4:0] OP_MOV  = 5'd25;
	localparam logic [4:0] OP_BIC  = 5'd26;
	localparam logic [4:0] OP_MVN  = 5'd27;

	// micro-op kinds
	localparam logic [4:0] K_FALLBACK    = 5'd0;
	localparam logic [4:0] K_NOP         = 5'd1;
	localparam logic [4:0] K_BRANCH      = 5'd2;
	localparam logic [4:0] K_BRANCH_COND = 5'd3;
	localparam logic [4:0] K_LI          = 5'd4;
	localparam logic [4:0] K_LOAD32      = 5'd5;
	localparam logic [4:0] K_LOAD8       = 5'd6;
	localparam logic [4:0] K_STORE32     = 5'd7;
	localparam logic [4:0] K_STORE8      = 5'd8;
	localparam logic [4:0] K_LSL         = 5'd9;
	localparam logic [4:0] K_AND         = 5'd13;
	localparam logic [4:0] K_EOR         = 5'd14;
	localparam logic [4:0] K_SUB         = 5'd15;
	localparam logic [4:0] K_RSB         = 5'd16;
	localparam logic [4:0] K_ADD         = 5'd17;
	localparam logic [4:0] K_ADC         = 5'd18;
	localparam logic [4:0] K_SBC         = 5'd19;
	localparam logic [4:0] K_RSC         = 5'd20;
	localparam logic [4:0] K_ORR         = 5'd21;
	localparam logic [4:0] K_MOV         = 5'd22;
	localparam logic [4:0] K_BIC         = 5'd23;
	localparam logic [4:0] K_MVN         = 5'd24;
	localparam logic [4:0] K_NZCV_ADD    = 5'd25;
	localparam logic [4:0] K_NZCV_SUB    = 5'd26;
	localparam logic [4:0] K_NZ          = 5'd27;

	// virtual registers
	localparam logic [4:0] VR_LR    = 5'd14;
	localparam logic [4:0] VR_PC    = 5'd15;
	localparam logic [4:0] VR_NONE  = 5'd16;
	localparam logic [4:0] VR_CONST = 5'd17;
	localparam logic [4:0] VR_TMP0  = 5'd18;
	localparam logic [4:0] VR_TMP1  = 5'd19;

	typedef struct packed {
		logic [4:0]  opcode;
		logic [3:0]  cond;
		logic        uncond;
		logic [3:0]  rd;
		logic [3:0]  rn;
		logic [3:0]  rm;
		logic [31:0] immediate;
		logic        is_immediate;
		logic [11:0] shift_spec;
		logic        flag_wr;
		logic [31:0] insn_pc;
		logic [31:0] next_pc;
	} insn_t;

	typedef struct packed {
		logic [4:0]  uop_kind;
		logic [3:0]  uop_cond;
		logic        uop_always;
		logic [4:0]  dest_reg;
		logic [4:0]  source_one;
		logic [4:0]  source_two;
		logic [31:0] uop_immediate;
		logic [31:0] uop_pc;
		logic        last;
	} uop_t;

	typedef struct packed {
		uop_t [UOPS_MAX-1:0] uops;
		logic [CNT_W-1:0]    count;
	} pkt_t;

endpackage

FILE: rtl/core/auc_front.sv
// Front end: accepts an instruction, cracks it into a micro-op packet, holds it for the queue.
module auc_front
	import auc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  insn_t      insn,
	input  logic [1:0] limit,
	output logic       pkt_valid,
	input  logic       pkt_ready,
	output pkt_t       pkt
);

	function automatic uop_t mk(input insn_t i, input logic [4:0] kind, input logic alw,
			input logic [4:0] dst, input logic [4:0] s1, input logic [4:0] s2,
			input logic [31:0] imm);
		uop_t u;
		u.uop_kind      = kind;
		u.uop_cond      = i.cond;
		u.uop_always    = alw;
		u.dest_reg      = dst;
		u.source_one    = s1;
		u.source_two    = s2;
		u.uop_immediate = imm;
		u.uop_pc        = i.insn_pc;
		u.last          = 1'b0;
		return u;
	endfunction

	function automatic logic [4:0] alu_kind(input logic [4:0] op);
		logic [4:0] k;
		unique case (op)
			OP_AND, OP_TST: k = K_AND;
			OP_EOR, OP_TEQ: k = K_EOR;
			OP_SUB, OP_CMP: k = K_SUB;
			OP_RSB:         k = K_RSB;
			OP_ADD, OP_CMN: k = K_ADD;
			OP_ADC:         k = K_ADC;
			OP_SBC:         k = K_SBC;
			OP_RSC:         k = K_RSC;
			OP_ORR:         k = K_ORR;
			OP_MOV:         k = K_MOV;
			OP_BIC:         k = K_BIC;
			OP_MVN:         k = K_MVN;
			default:        k = K_FALLBACK;
		endcase
		return k;
	endfunction

	uop_t [UOPS_MAX-1:0] raw;
	logic [CNT_W-1:0]    n_raw;
	logic [CNT_W-1:0]    cnt;
	pkt_t                crack;
	logic [4:0]          rd_v, rn_v, rm_v, rs_v;
	logic                has_shift, is_move, is_cmp;
	logic [4:0]          op2, kind, dst, s1, s2;
	uop_t                main_u, flag_u;
	logic                accept;
	logic                valid_s1;
	pkt_t                pkt_s1;

	assign rd_v = {1'b0, insn.rd};
	assign rn_v = {1'b0, insn.rn};
	assign rm_v = {1'b0, insn.rm};
	assign rs_v = {1'b0, insn.shift_spec[11:8]};

	always_comb begin
		has_shift = !insn.is_immediate &&
			((insn.shift_spec[4:0] != 5'd0) || insn.shift_spec[7]);
		is_move = (insn.opcode == OP_MOV) || (insn.opcode == OP_MVN);
		is_cmp  = (insn.opcode == OP_TST) || (insn.opcode == OP_TEQ) ||
			(insn.opcode == OP_CMP) || (insn.opcode == OP_CMN);
		if (insn.is_immediate) begin
			op2 = VR_CONST;
		end else if (has_shift) begin
			op2 = VR_TMP0;
		end else begin
			op2 = rm_v;
		end
		kind = alu_kind(insn.opcode);
		if (insn.opcode == OP_MOV && op2 == VR_CONST) begin
			kind = K_LI;
		end
		dst = is_cmp ? VR_TMP1 : rd_v;
		if (is_move) begin
			s1 = (op2 == VR_CONST) ? VR_NONE : op2;
			s2 = VR_NONE;
		end else begin
			s1 = rn_v;
			s2 = op2;
		end
		main_u = mk(insn, kind, insn.uncond, dst, s1, s2, insn.immediate);
		if (insn.opcode == OP_ADD || insn.opcode == OP_CMN) begin
			flag_u = mk(insn, K_NZCV_ADD, insn.uncond, dst, s1, s2, insn.immediate);
		end else if (insn.opcode == OP_SUB || insn.opcode == OP_CMP) begin
			flag_u = mk(insn, K_NZCV_SUB, insn.uncond, dst, s1, s2, insn.immediate);
		end else begin
			flag_u = mk(insn, K_NZ, insn.uncond, dst, VR_NONE, VR_NONE, 32'd0);
		end
	end

	always_comb begin
		raw   = '0;
		n_raw = CNT_W'(1);
		unique case (insn.opcode)
			OP_NOP: begin
				raw[0] = mk(insn, K_NOP, insn.uncond, VR_NONE, VR_NONE, VR_NONE, 32'd0);
			end
			OP_B: begin
				if (insn.uncond) begin
					raw[0] = mk(insn, K_BRANCH, 1'b1, VR_PC, VR_CONST, VR_NONE,
						insn.immediate);
				end else begin
					raw[0] = mk(insn, K_BRANCH_COND, 1'b0, VR_PC, VR_CONST, VR_CONST,
						insn.immediate);
				end
			end
			OP_BL: begin
				raw[0] = mk(insn, K_LI, insn.uncond, VR_LR, VR_CONST, VR_NONE,
					insn.next_pc);
				raw[1] = mk(insn, K_BRANCH, insn.uncond, VR_PC, VR_CONST, VR_NONE,
					insn.immediate);
				n_raw  = CNT_W'(2);
			end
			OP_BX: begin
				raw[0] = mk(insn, K_BRANCH, insn.uncond, VR_PC, rm_v, VR_NONE, 32'd0);
			end
			OP_BLX: begin
				raw[0] = mk(insn, K_LI, insn.uncond, VR_LR, VR_CONST, VR_NONE,
					insn.next_pc);
				raw[1] = mk(insn, K_BRANCH, insn.uncond, VR_PC, rm_v, VR_NONE, 32'd0);
				n_raw  = CNT_W'(2);
			end
			OP_LDR, OP_LDRB: begin
				raw[0] = mk(insn, (insn.opcode == OP_LDR) ? K_LOAD32 : K_LOAD8,
					insn.uncond, rd_v, rn_v, VR_CONST, insn.immediate);
			end
			OP_STR, OP_STRB: begin
				raw[0] = mk(insn, (insn.opcode == OP_STR) ? K_STORE32 : K_STORE8,
					insn.uncond, VR_NONE, rn_v, rd_v, insn.immediate);
			end
			default: begin
				if (insn.opcode >= OP_AND && insn.opcode <= OP_MVN) begin
					if (has_shift) begin
						raw[0] = mk(insn, K_LSL + {3'b000, insn.shift_spec[6:5]},
							insn.uncond, VR_TMP0, rm_v,
							insn.shift_spec[7] ? rs_v : VR_CONST,
							{27'd0, insn.shift_spec[4:0]});
						raw[1] = main_u;
						raw[2] = flag_u;
						n_raw  = insn.flag_wr ? CNT_W'(3) : CNT_W'(2);
					end else begin
						raw[0] = main_u;
						raw[1] = flag_u;
						n_raw  = insn.flag_wr ? CNT_W'(2) : CNT_W'(1);
					end
				end else begin
					raw[0] = mk(insn, K_FALLBACK, insn.uncond, VR_NONE, VR_NONE,
						VR_NONE, 32'd0);
				end
			end
		endcase
	end

	always_comb begin
		cnt = (n_raw < limit) ? n_raw : limit;
		crack.count = cnt;
		for (int i = 0; i < UOPS_MAX; i++) begin
			crack.uops[i]      = raw[i];
			crack.uops[i].last = (CNT_W'(i + 1) == cnt);
		end
	end

	assign full   = valid_s1 && !pkt_ready;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (limit != 2'd0);
		end else if (pkt_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pkt_s1 <= crack;
		end
	end

	assign pkt_valid = valid_s1;
	assign pkt       = pkt_s1;

endmodule

FILE: rtl/core/auc_queue.sv
// Short packet queue between the cracking front end and the issuing back end.
module auc_queue
	import auc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  pkt_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output pkt_t rd_data
);

	pkt_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr, do_rd;

	assign wr_ready = (count_q != QCNT_W'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: rtl/core/auc_back.sv
// Back end: steps a packet into the result register, one micro-op per cycle if pop allows.
module auc_back
	import auc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic pkt_valid,
	output logic pkt_ready,
	input  pkt_t pkt,
	output logic empty,
	input  logic pop,
	output uop_t uop
);

	logic [CNT_W-1:0] idx_q;
	logic             out_valid_q;
	uop_t             out_q;
	logic             load, at_end;

	assign load      = pkt_valid && (!out_valid_q || pop);
	assign at_end    = (idx_q == pkt.count - 1'b1);
	assign pkt_ready = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= at_end ? '0 : idx_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= pkt.uops[idx_q];
		end
	end

	assign empty = !out_valid_q;
	assign uop   = out_q;

endmodule

FILE: rtl/core/arm_insn_uop_cracker.sv
// Top level of the ARM instruction to micro-op cracker.
//
// Input: a pre-decoded instruction on insn is taken at a clock edge with push high
// and full low. Output: while empty is low, uop holds the oldest pending micro-op;
// it is taken at an edge with pop high. The last micro-op of an instruction has
// last set. cfg_data sets the per-instruction micro-op limit when cfg_valid is high
// (cfg_ready is always high); a limit of zero drops instructions entirely.
// A micro-op passes through the crack register, the queue and the result register
// on its way from push to uop. The back end issues one micro-op per cycle while a
// packet is waiting and the result register is empty or being popped.
// A two-entry packet queue lets the front keep accepting while the back issues.
// Reset empties the front register, queue and result register and sets the limit
// to three. When pop stays low the result register holds, the queue fills, and then
// full rises; nothing is lost.
module arm_insn_uop_cracker
	import auc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  insn_t      insn,
	output logic       empty,
	input  logic       pop,
	output uop_t       uop,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data
);

	logic [1:0] limit_q;
	logic       f_valid, f_ready, b_valid, b_ready;
	pkt_t       f_pkt, b_pkt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	auc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.insn      (insn),
		.limit     (limit_q),
		.pkt_valid (f_valid),
		.pkt_ready (f_ready),
		.pkt       (f_pkt)
	);

	auc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_pkt),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_pkt)
	);

	auc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (b_valid),
		.pkt_ready (b_ready),
		.pkt       (b_pkt),
		.empty     (empty),
		.pop       (pop),
		.uop       (uop)
	);

endmodule

FILE: tb/tb_arm_insn_uop_cracker.sv
// Self-checking testbench for arm_insn_uop_cracker: directed and random instructions, predicted micro-ops.
module tb_arm_insn_uop_cracker;
	import auc_pkg::*;

	localparam logic [4:0] OP_FALLBACK = 5'd0;
	localparam logic [4:0] OP_CPS      = 5'd1;
	localparam logic [4:0] OP_SVC      = 5'd2;
	localparam logic [4:0] OP_OTHER    = 5'd28;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_PAUSE    = 20;
	localparam int HOLD_CYCLES    = 300;

	class uop_scoreboard;
		logic [1:0]  limit = LIMIT_RESET;
		uop_t        pending_uops[$];
		uop_t        staged[$];
		logic [3:0]  cur_cond;
		logic        cur_always;
		logic [31:0] cur_pc;
		int          insns_seen = 0;
		int          uops_seen = 0;
		int          fails = 0;

		task report(string what, logic [31:0] got_v, logic [31:0] exp_v);
			$display("mismatch %s: got %h expected %h at %0t", what, got_v, exp_v, $time);
			fails++;
		endtask

		function void stage(logic [4:0] kind, logic uncond, logic [4:0] dst, logic [4:0] s1,
				logic [4:0] s2, logic [31:0] imm);
			uop_t u;
			if (staged.size() >= int'(limit))
				return;
			u.uop_kind      = kind;
			u.uop_cond      = cur_cond;
			u.uop_always    = uncond;
			u.dest_reg      = dst;
			u.source_one    = s1;
			u.source_two    = s2;
			u.uop_immediate = imm;
			u.uop_pc        = cur_pc;
			u.last          = 1'b0;
			staged.push_back(u);
		endfunction

		// crack one accepted instruction into its expected micro-ops
		function void note_insn(insn_t t);
			logic [4:0] rd, rn, rm, op2, kind, dst, s1, s2;
			logic is_move, is_cmp;
			staged.delete();
			cur_cond   = t.cond;
			cur_always = t.uncond;
			cur_pc     = t.insn_pc;
			rd = {1'b0, t.rd};
			rn = {1'b0, t.rn};
			rm = {1'b0, t.rm};
			case (t.opcode)
				OP_NOP: stage(K_NOP, cur_always, VR_NONE, VR_NONE, VR_NONE, 32'd0);
				OP_B: begin
					if (t.uncond)
						stage(K_BRANCH, 1'b1, VR_PC, VR_CONST, VR_NONE, t.immediate);
					else
						stage(K_BRANCH_COND, 1'b0, VR_PC, VR_CONST, VR_CONST, t.immediate);
				end
				OP_BL: begin
					stage(K_LI, cur_always, VR_LR, VR_CONST, VR_NONE, t.next_pc);
					stage(K_BRANCH, cur_always, VR_PC, VR_CONST, VR_NONE, t.immediate);
				end
				OP_BX, OP_BLX: begin
					if (t.opcode == OP_BLX)
						stage(K_LI, cur_always, VR_LR, VR_CONST, VR_NONE, t.next_pc);
					stage(K_BRANCH, cur_always, VR_PC, rm, VR_NONE, 32'd0);
				end
				OP_LDR, OP_LDRB:
					stage((t.opcode == OP_LDR) ? K_LOAD32 : K_LOAD8, cur_always, rd, rn,
						VR_CONST, t.immediate);
				OP_STR, OP_STRB:
					stage((t.opcode == OP_STR) ? K_STORE32 : K_STORE8, cur_always, VR_NONE, rn,
						rd, t.immediate);
				default: begin
					if (t.opcode >= OP_AND && t.opcode <= OP_MVN) begin
						if (t.is_immediate)
							op2 = VR_CONST;
						else if (t.shift_spec[4:0] == 5'd0 && !t.shift_spec[7])
							op2 = rm;
						else begin
							stage(K_LSL + {3'b000, t.shift_spec[6:5]}, cur_always, VR_TMP0, rm,
								t.shift_spec[7] ? {1'b0, t.shift_spec[11:8]} : VR_CONST,
								{27'd0, t.shift_spec[4:0]});
							op2 = VR_TMP0;
						end
						case (t.opcode)
							OP_AND, OP_TST: kind = K_AND;
							OP_EOR, OP_TEQ: kind = K_EOR;
							OP_SUB, OP_CMP: kind = K_SUB;
							OP_RSB:         kind = K_RSB;
							OP_ADD, OP_CMN: kind = K_ADD;
							OP_ADC:         kind = K_ADC;
							OP_SBC:         kind = K_SBC;
							OP_RSC:         kind = K_RSC;
							OP_ORR:         kind = K_ORR;
							OP_MOV:         kind = K_MOV;
							OP_BIC:         kind = K_BIC;
							default:        kind = K_MVN;
						endcase
						if (t.opcode == OP_MOV && op2 == VR_CONST)
							kind = K_LI;
						is_cmp  = (t.opcode >= OP_TST && t.opcode <= OP_CMN);
						is_move = (t.opcode == OP_MOV || t.opcode == OP_MVN);
						dst = is_cmp ? VR_TMP1 : rd;
						if (is_move) begin
							s1 = (op2 == VR_CONST) ? VR_NONE : op2;
							s2 = VR_NONE;
						end else begin
							s1 = rn;
							s2 = op2;
						end
						stage(kind, cur_always, dst, s1, s2, t.immediate);
						if (t.flag_wr) begin
							if (t.opcode == OP_ADD || t.opcode == OP_CMN)
								stage(K_NZCV_ADD, cur_always, dst, s1, s2, t.immediate);
							else if (t.opcode == OP_SUB || t.opcode == OP_CMP)
								stage(K_NZCV_SUB, cur_always, dst, s1, s2, t.immediate);
							else
								stage(K_NZ, cur_always, dst, VR_NONE, VR_NONE, 32'd0);
						end
					end else begin
						stage(K_FALLBACK, cur_always, VR_NONE, VR_NONE, VR_NONE, 32'd0);
					end
				end
			endcase
			if (staged.size() > 0)
				staged[staged.size()-1].last = 1'b1;
			foreach (staged[i])
				pending_uops.push_back(staged[i]);
			insns_seen++;
		endfunction

		task check_field(string name, logic [31:0] got_v, logic [31:0] exp_v);
			if (got_v !== exp_v)
				report(name, got_v, exp_v);
		endtask

		task check_uop(uop_t got);
			uop_t want;
			uops_seen++;
			if (pending_uops.size() == 0) begin
				report("micro-op with none pending, pc", got.uop_pc, 32'd0);
				return;
			end
			want = pending_uops.pop_front();
			check_field("uop_kind", 32'(got.uop_kind), 32'(want.uop_kind));
			check_field("uop_cond", 32'(got.uop_cond), 32'(want.uop_cond));
			check_field("uop_always", 32'(got.uop_always), 32'(want.uop_always));
			check_field("dest_reg", 32'(got.dest_reg), 32'(want.dest_reg));
			check_field("source_one", 32'(got.source_one), 32'(want.source_one));
			check_field("source_two", 32'(got.source_two), 32'(want.source_two));
			check_field("uop_immediate", got.uop_immediate, want.uop_immediate);
			check_field("uop_pc", got.uop_pc, want.uop_pc);
			check_field("last", 32'(got.last), 32'(want.last));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	insn_t      insn;
	logic       empty;
	logic       pop;
	uop_t       uop;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_data;

	uop_scoreboard sb;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_gen       = 0;

	arm_insn_uop_cracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.insn      (insn),
		.empty     (empty),
		.pop       (pop),
		.uop       (uop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic insn_t rand_insn();
		insn_t t;
		int pick;
		pick = $urandom_range(99);
		if (pick < 60)
			t.opcode = 5'($urandom_range(int'(OP_MVN), int'(OP_AND)));
		else if (pick < 75)
			t.opcode = 5'($urandom_range(int'(OP_BLX), int'(OP_NOP)));
		else if (pick < 90)
			t.opcode = 5'($urandom_range(int'(OP_STRB), int'(OP_LDR)));
		else
			t.opcode = 5'($urandom_range(31, 0));
		t.cond         = 4'($urandom);
		t.uncond       = 1'($urandom);
		t.rd           = 4'($urandom);
		t.rn           = 4'($urandom);
		t.rm           = 4'($urandom);
		t.immediate    = $urandom;
		t.is_immediate = 1'($urandom);
		t.shift_spec   = 12'($urandom);
		t.flag_wr      = 1'($urandom);
		t.insn_pc      = $urandom;
		t.next_pc      = $urandom;
		pick = $urandom_range(9);
		if (pick == 0)
			t.immediate = 32'd0;
		else if (pick == 1)
			t.immediate = 32'hffff_ffff;
		if ($urandom_range(2) == 0)
			t.shift_spec[4:0] = 5'd0;
		return t;
	endfunction

	task send_insn(input insn_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		insn <= t;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_insn(t);
	endtask

	task wait_idle();
		push <= 1'b0;
		while (sb.pending_uops.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	task write_limit(input logic [1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.limit = value;
	endtask

	task run_random(input int count);
		repeat (count) send_insn(rand_insn());
	endtask

	task run_directed();
		insn_t t;
		t = '0;
		send_insn(t);
		t = rand_insn(); t.opcode = OP_CPS; send_insn(t);
		t = rand_insn(); t.opcode = OP_SVC; send_insn(t);
		t = rand_insn(); t.opcode = OP_NOP; send_insn(t);
		t = rand_insn(); t.opcode = OP_B; t.uncond = 1'b1; send_insn(t);
		t = rand_insn(); t.opcode = OP_B; t.uncond = 1'b0; send_insn(t);
		t = rand_insn(); t.opcode = OP_BL; send_insn(t);
		t = rand_insn(); t.opcode = OP_BX; send_insn(t);
		t = rand_insn(); t.opcode = OP_BLX; send_insn(t);
		t = rand_insn(); t.opcode = OP_LDR; t.immediate = 32'hffff_ffff; send_insn(t);
		t = rand_insn(); t.opcode = OP_LDRB; send_insn(t);
		t = rand_insn(); t.opcode = OP_STR; send_insn(t);
		t = rand_insn(); t.opcode = OP_STRB; t.immediate = 32'd0; send_insn(t);
		// shift by constant, largest amount, ror
		t = rand_insn(); t.opcode = OP_AND; t.is_immediate = 1'b0;
		t.shift_spec = {4'hf, 1'b0, 2'b11, 5'd31}; t.flag_wr = 1'b1; send_insn(t);
		t = rand_insn(); t.opcode = OP_SUB; t.is_immediate = 1'b1; t.flag_wr = 1'b1;
		send_insn(t);
		// shift by register gives three micro-ops
		t = rand_insn(); t.opcode = OP_ADD; t.is_immediate = 1'b0;
		t.shift_spec = {4'h9, 1'b1, 2'b01, 5'd7}; t.flag_wr = 1'b1; send_insn(t);
		t = rand_insn(); t.opcode = OP_CMP; t.is_immediate = 1'b0; t.flag_wr = 1'b1;
		send_insn(t);
		t = rand_insn(); t.opcode = OP_CMN; t.is_immediate = 1'b1; t.flag_wr = 1'b1;
		send_insn(t);
		t = rand_insn(); t.opcode = OP_MOV; t.is_immediate = 1'b1; t.flag_wr = 1'b1;
		send_insn(t);
		// zero amount with a shift type set: operand used directly
		t = rand_insn(); t.opcode = OP_MOV; t.is_immediate = 1'b0;
		t.shift_spec = {4'h3, 1'b0, 2'b10, 5'd0}; send_insn(t);
		// shift by register with zero amount still shifts
		t = rand_insn(); t.opcode = OP_MVN; t.is_immediate = 1'b0;
		t.shift_spec = {4'h0, 1'b1, 2'b00, 5'd0}; t.flag_wr = 1'b1; send_insn(t);
		t = rand_insn(); t.opcode = OP_TST; t.flag_wr = 1'b1; send_insn(t);
		t = rand_insn(); t.opcode = OP_TEQ; t.flag_wr = 1'b0; send_insn(t);
		t = rand_insn(); t.opcode = OP_OTHER; send_insn(t);
		t = '1;
		send_insn(t);
	endtask

	// result side
	initial begin : result_side
		int held;
		int seen_gen;
		held = 0;
		seen_gen = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_gen != seen_gen) begin
				seen_gen = hold_gen;
				held = HOLD_CYCLES;
			end
			if (held > 0) begin
				pop <= 1'b0;
				held--;
			end else
				pop <= ($urandom_range(99) >= recv_stall_pct);
			@(posedge clk);
			if (pop && !empty)
				sb.check_uop(uop);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || cfg_valid || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		int n;
		sb = new();
		arst_n    = 1'b0;
		push      = 1'b0;
		insn      = '0;
		cfg_valid = 1'b0;
		cfg_data  = 2'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		write_limit(2'd2);
		run_random(100);

		write_limit(2'd1);
		send_idle_pct = 83;
		run_random(100);

		write_limit(2'd3);
		send_idle_pct  = 0;
		recv_stall_pct = 83;
		hold_gen++;
		run_random(100);

		write_limit(2'd0);
		send_idle_pct  = 11;
		recv_stall_pct = 11;
		run_random(10);

		write_limit(2'd3);
		run_random(100);

		write_limit(2'd2);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random(100);

		push <= 1'b0;
		n = 0;
		while (sb.pending_uops.size() != 0 && n < WATCHDOG_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (DRAIN_PAUSE) @(posedge clk);
		if (sb.pending_uops.size() != 0)
			sb.report("micro-ops never delivered, count", 32'(sb.pending_uops.size()), 32'd0);

		$display("covered %0d instructions and %0d micro-ops, limits 0 to 3, idle and stall mixes",
			sb.insns_seen, sb.uops_seen);
		$display("mismatches: %0d", sb.fails);
		if (sb.fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
